// ----- design/pes_pkg.sv -----
// Package with shared types and constants for the periodic event scheduler.
package pes_pkg;

    localparam int ID_W     = 16;
    localparam int PERIOD_W = 16;
    localparam int DUE_W    = 32;

    localparam logic [DUE_W-1:0] DUE_MAX = {DUE_W{1'b1}};

    // Kind of input word, carried in s_tuser.
    localparam logic FUNC_ADD  = 1'b0;
    localparam logic FUNC_NEXT = 1'b1;

    // Kind of result word, carried in m_tuser.
    localparam logic STATUS_EVENT = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    // One table entry as it is stored in the entry memory.
    typedef struct packed {
        logic [DUE_W-1:0]    due;
        logic [PERIOD_W-1:0] period;
        logic [ID_W-1:0]     id;
    } pes_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WB
    } pes_state_t;

endpackage

// ----- design/pes_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
module pes_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/periodic_event_scheduler.sv -----
// Top level of the periodic event scheduler: entry table, scan sequencer and result register.
//
//  Channel   Direction  tdata (low bits first)                 tuser
//  s_        in         query_id[15:0], period[31:16]          func (0 add, 1 next)
//  m_        out        event_query_id[15:0], event_time[47:16] status (0 event, 1 empty)
//
// An add word writes the entry straight into the entry memory,
// and the block is ready for the next word in the following cycle.
// A next word scans the N stored entries: the scan reads one entry per cycle from the
// single read port of the entry memory, which has a registered read, and then the
// winner's advanced due time is written back in the write-back state.
// Reset clears only the entry count, the control state and the result valid flag; the memory needs no clearing.
// A stalled result holds the write-back cycle until the result register frees up.
module periodic_event_scheduler #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // query_id[15:0], period[31:16]
    input  logic        s_tuser,   // func[0]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // event_query_id[15:0], event_time[47:16]
    output logic        m_tuser    // status[0]
);

    // Address width of the entry memory and width of a count that can hold MAX_ENTRIES.
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int EW = $bits(pes_pkg::pes_entry_t);

    // Control state.
    pes_pkg::pes_state_t state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       iss_reg, iss_next;      // next entry to read during a scan
    logic                rvalid_reg, rvalid_next; // read data from the memory is valid
    logic [AW-1:0]       rd_idx_reg, rd_idx_next; // index of the entry on the read data
    logic                found_reg, found_next;
    logic                empty_reg, empty_next;

    // Running best entry of the scan.
    logic [AW-1:0]                best_idx_reg, best_idx_next;
    logic [pes_pkg::ID_W-1:0]     best_id_reg, best_id_next;
    logic [pes_pkg::PERIOD_W-1:0] best_per_reg, best_per_next;
    logic [pes_pkg::DUE_W-1:0]    best_due_reg, best_due_next;

    // Result register.
    logic        m_tvalid_reg;
    logic [47:0] m_tdata_reg;
    logic        m_tuser_reg;

    // Entry memory ports.
    logic                 ram_wr_en;
    logic [AW-1:0]        ram_wr_addr;
    pes_pkg::pes_entry_t  ram_wr_data;
    logic                 ram_rd_en;
    logic [AW-1:0]        ram_rd_addr;
    logic [EW-1:0]        ram_rd_raw;
    pes_pkg::pes_entry_t  ram_rd_data;

    logic                         out_free;
    logic                         out_load;
    logic                         s_accept;
    logic                         in_func;
    logic [pes_pkg::ID_W-1:0]     in_id;
    logic [pes_pkg::PERIOD_W-1:0] in_period;
    logic [pes_pkg::DUE_W:0]      due_sum;
    logic [pes_pkg::DUE_W-1:0]    due_adv;
    logic                         better;

    assign in_func   = s_tuser;
    assign in_id     = s_tdata[15:0];
    assign in_period = s_tdata[31:16];

    // Words are taken only between scans; adds never overlap a scan, so the
    // memory sees no read and write of the same entry in one cycle.
    assign s_tready = (state_reg == pes_pkg::ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign ram_rd_addr = iss_reg[AW-1:0];
    assign ram_rd_data = pes_pkg::pes_entry_t'(ram_rd_raw);

    // Saturating advance of the winning entry's due time.
    assign due_sum = {1'b0, best_due_reg} + (pes_pkg::DUE_W + 1)'(best_per_reg);
    assign due_adv = due_sum[pes_pkg::DUE_W] ? pes_pkg::DUE_MAX : due_sum[pes_pkg::DUE_W-1:0];

    // Smaller due time wins; on equal due times the smaller identifier wins, and the
    // strict compare keeps the earlier entry when both are equal.
    assign better = !found_reg
                 || (ram_rd_data.due < best_due_reg)
                 || ((ram_rd_data.due == best_due_reg) && (ram_rd_data.id < best_id_reg));

    pes_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_ENTRIES)
    ) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_raw)
    );

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        iss_next      = iss_reg;
        rvalid_next   = 1'b0;
        rd_idx_next   = rd_idx_reg;
        found_next    = found_reg;
        empty_next    = empty_reg;
        best_idx_next = best_idx_reg;
        best_id_next  = best_id_reg;
        best_per_next = best_per_reg;
        best_due_next = best_due_reg;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = best_idx_reg;
        ram_wr_data   = '{due: due_adv, period: best_per_reg, id: best_id_reg};
        ram_rd_en     = 1'b0;
        out_load      = 1'b0;

        case (state_reg)
            pes_pkg::ST_IDLE: begin
                if (s_accept) begin
                    if (in_func == pes_pkg::FUNC_ADD) begin
                        // An add to a full table is dropped.
                        if (count_reg != CW'(MAX_ENTRIES)) begin
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = count_reg[AW-1:0];
                            ram_wr_data = '{due: pes_pkg::DUE_W'(in_period),
                                            period: in_period, id: in_id};
                            count_next  = count_reg + CW'(1);
                        end
                    end else begin
                        found_next = 1'b0;
                        iss_next   = '0;
                        if (count_reg == '0) begin
                            empty_next = 1'b1;
                            state_next = pes_pkg::ST_WB;
                        end else begin
                            empty_next = 1'b0;
                            state_next = pes_pkg::ST_SCAN;
                        end
                    end
                end
            end

            pes_pkg::ST_SCAN: begin
                if (iss_reg != count_reg) begin
                    ram_rd_en   = 1'b1;
                    rd_idx_next = iss_reg[AW-1:0];
                    iss_next    = iss_reg + CW'(1);
                    rvalid_next = 1'b1;
                end
                if (rvalid_reg) begin
                    if (better) begin
                        best_idx_next = rd_idx_reg;
                        best_id_next  = ram_rd_data.id;
                        best_per_next = ram_rd_data.period;
                        best_due_next = ram_rd_data.due;
                        found_next    = 1'b1;
                    end
                    if (iss_reg == count_reg) begin
                        state_next = pes_pkg::ST_WB;
                    end
                end
            end

            pes_pkg::ST_WB: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    ram_wr_en  = !empty_reg;
                    state_next = pes_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = pes_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= pes_pkg::ST_IDLE;
            count_reg    <= '0;
            rvalid_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rvalid_reg <= rvalid_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        iss_reg      <= iss_next;
        rd_idx_reg   <= rd_idx_next;
        found_reg    <= found_next;
        empty_reg    <= empty_next;
        best_idx_reg <= best_idx_next;
        best_id_reg  <= best_id_next;
        best_per_reg <= best_per_next;
        best_due_reg <= best_due_next;
        if (out_load) begin
            m_tuser_reg <= empty_reg ? pes_pkg::STATUS_EMPTY : pes_pkg::STATUS_EVENT;
            m_tdata_reg <= empty_reg ? 48'd0 : {best_due_reg, best_id_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_ENTRIES))
        else $error("entry count above table size");

    a_full_add_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (in_func == pes_pkg::FUNC_ADD) && (count_reg == CW'(MAX_ENTRIES)))
        |=> $stable(count_reg))
        else $error("add to a full table changed the count");

    a_scan_count_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pes_pkg::ST_SCAN) |=> $stable(count_reg))
        else $error("entry count changed during a scan");

    a_wb_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == pes_pkg::ST_WB) && ram_wr_en) |-> (CW'(best_idx_reg) < count_reg))
        else $error("write-back to an entry that is not stored");

    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && empty_reg) |-> (count_reg == '0))
        else $error("empty status with stored entries");
`endif

endmodule

// ----- sim/periodic_event_scheduler_tb.sv -----
// Self-checking testbench for the periodic event scheduler: random handshakes and a predicting scoreboard.
module periodic_event_scheduler_tb;

    localparam int MAX_ENTRIES  = 64;
    localparam int RANDOM_WORDS = 930;
    // About a third of all words goes to each idling phase.
    localparam int PHASE_WORDS  = 322;
    // A next word scans every entry once, plus read latency and write-back.
    localparam int DRAIN_CYCLES = MAX_ENTRIES + 8;

    typedef struct {
        logic                        status;
        logic [pes_pkg::ID_W-1:0]    query_id;
        logic [pes_pkg::DUE_W-1:0]   due;
    } sched_result_t;

    // Mirrors the entry table and holds the events still owed by the block.
    class event_schedule_tracker;
        logic [pes_pkg::ID_W-1:0]     ids     [MAX_ENTRIES];
        logic [pes_pkg::PERIOD_W-1:0] periods [MAX_ENTRIES];
        logic [pes_pkg::DUE_W-1:0]    dues    [MAX_ENTRIES];
        int                           stored;
        sched_result_t                owed_events [$];
        int                           mismatches;

        function new();
            stored     = 0;
            mismatches = 0;
        endfunction

        task report(string msg);
            $display("%0t mismatch: %s", $time, msg);
            mismatches++;
        endtask

        // Called for every word the block accepts.
        function void note_word(logic func, logic [pes_pkg::ID_W-1:0] qid,
                                logic [pes_pkg::PERIOD_W-1:0] per);
            int                      best;
            logic [pes_pkg::DUE_W:0] sum;
            sched_result_t           ev;
            if (func == pes_pkg::FUNC_ADD) begin
                // An add to a full table is dropped without a result.
                if (stored < MAX_ENTRIES) begin
                    ids[stored]     = qid;
                    periods[stored] = per;
                    dues[stored]    = pes_pkg::DUE_W'(per);
                    stored++;
                end
                return;
            end
            if (stored == 0) begin
                ev.status   = pes_pkg::STATUS_EMPTY;
                ev.query_id = '0;
                ev.due      = '0;
                owed_events = {owed_events, ev};
                return;
            end
            // Earliest due time wins, then the smaller id; on a full tie the older entry.
            best = 0;
            for (int i = 1; i < stored; i++) begin
                if (dues[i] < dues[best] || (dues[i] == dues[best] && ids[i] < ids[best]))
                    best = i;
            end
            ev.status   = pes_pkg::STATUS_EVENT;
            ev.query_id = ids[best];
            ev.due      = dues[best];
            owed_events = {owed_events, ev};
            sum = {1'b0, dues[best]}
                + {{(pes_pkg::DUE_W+1-pes_pkg::PERIOD_W){1'b0}}, periods[best]};
            dues[best] = sum[pes_pkg::DUE_W] ? pes_pkg::DUE_MAX : sum[pes_pkg::DUE_W-1:0];
        endfunction

        task check_result(logic status, logic [pes_pkg::ID_W-1:0] qid,
                          logic [pes_pkg::DUE_W-1:0] due);
            sched_result_t want;
            if (owed_events.size() == 0) begin
                report($sformatf("unexpected result status %0d id %h time %h", status, qid, due));
                return;
            end
            want = owed_events.pop_front();
            if (status !== want.status)
                report($sformatf("status %0d, wanted %0d", status, want.status));
            if (qid !== want.query_id)
                report($sformatf("query id %h, wanted %h", qid, want.query_id));
            if (due !== want.due)
                report($sformatf("event time %h, wanted %h", due, want.due));
        endtask
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        s_tuser  = pes_pkg::FUNC_ADD;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;

    int send_idle   = 8;
    int recv_idle   = 87;
    int words_sent  = 0;

    event_schedule_tracker tracker;

    periodic_event_scheduler #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Result side: check every accepted word, then pick the next ready level.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_result(m_tuser, m_tdata[15:0], m_tdata[47:16]);
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    // Presents one word after a random gap and returns at the edge that takes it.
    task automatic send_word(logic func, logic [pes_pkg::ID_W-1:0] qid,
                             logic [pes_pkg::PERIOD_W-1:0] per);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {per, qid};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        tracker.note_word(func, qid, per);
        words_sent++;
        if (words_sent < PHASE_WORDS) begin
            send_idle = 8;
            recv_idle = 87;
        end else if (words_sent < 2 * PHASE_WORDS) begin
            send_idle = 87;
            recv_idle = 8;
        end else begin
            send_idle = 0;
            recv_idle = 0;
        end
    endtask

    initial begin
        logic [pes_pkg::ID_W-1:0]     qid;
        logic [pes_pkg::PERIOD_W-1:0] per;
        int                           pick;

        tracker = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty table, with the ignored fields at both extremes.
        send_word(pes_pkg::FUNC_NEXT, 16'h0000, 16'h0001);
        send_word(pes_pkg::FUNC_NEXT, 16'hFFFF, 16'hFFFF);
        // Largest id and period, then the smallest id with a period of one.
        send_word(pes_pkg::FUNC_ADD, 16'hFFFF, 16'hFFFF);
        send_word(pes_pkg::FUNC_ADD, 16'h0000, 16'h0001);
        send_word(pes_pkg::FUNC_NEXT, 16'h0000, 16'h0000);
        send_word(pes_pkg::FUNC_NEXT, 16'h0000, 16'h0000);
        // Equal due times: a duplicate entry and a smaller id meet the id 0 entry.
        send_word(pes_pkg::FUNC_ADD, 16'h0007, 16'h0003);
        send_word(pes_pkg::FUNC_ADD, 16'h0007, 16'h0003);
        send_word(pes_pkg::FUNC_ADD, 16'h0006, 16'h0003);
        repeat (4) send_word(pes_pkg::FUNC_NEXT, 16'h0000, 16'h0000);
        send_word(pes_pkg::FUNC_ADD, 16'h8000, 16'h8000);
        send_word(pes_pkg::FUNC_ADD, 16'h5A5A, 16'h00FF);
        send_word(pes_pkg::FUNC_ADD, 16'h00FF, 16'hFF00);
        repeat (5) send_word(pes_pkg::FUNC_NEXT, 16'hA5A5, 16'h5A5A);

        // Random part: fill the table up to one slot short, mostly with small ids and
        // short periods so that ties and repeated winners are common, while nexts run.
        repeat (RANDOM_WORDS) begin
            if (tracker.stored < MAX_ENTRIES - 1 && $urandom_range(99) < 35) begin
                pick = $urandom_range(99);
                if (pick < 70)
                    qid = pes_pkg::ID_W'($urandom_range(15));
                else
                    qid = pes_pkg::ID_W'($urandom);
                pick = $urandom_range(99);
                if (pick < 60)
                    per = pes_pkg::PERIOD_W'($urandom_range(16, 1));
                else if (pick < 90)
                    per = pes_pkg::PERIOD_W'($urandom_range(1024, 17));
                else
                    per = pes_pkg::PERIOD_W'($urandom_range(65535, 1));
                send_word(pes_pkg::FUNC_ADD, qid, per);
            end else begin
                send_word(pes_pkg::FUNC_NEXT, pes_pkg::ID_W'($urandom),
                          pes_pkg::PERIOD_W'($urandom));
            end
        end
        while (tracker.stored < MAX_ENTRIES - 1)
            send_word(pes_pkg::FUNC_ADD, pes_pkg::ID_W'($urandom),
                      pes_pkg::PERIOD_W'($urandom_range(65535, 1)));

        // The last slot gets a zero period, whose due time never moves; then the
        // table is full and further adds must be dropped.
        send_word(pes_pkg::FUNC_ADD, pes_pkg::ID_W'($urandom_range(31)), 16'h0000);
        repeat (3) send_word(pes_pkg::FUNC_ADD, pes_pkg::ID_W'($urandom),
                             pes_pkg::PERIOD_W'($urandom_range(65535, 1)));
        repeat (10) send_word(pes_pkg::FUNC_NEXT, pes_pkg::ID_W'($urandom),
                              pes_pkg::PERIOD_W'($urandom));

        s_tvalid <= 1'b0;
        while (tracker.owed_events.size() != 0)
            @(posedge aclk);
        // Anything arriving now has no expectation and is flagged by the checker.
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (tracker.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #5000000;
        $display("status: fail");
        $finish;
    end

endmodule
